// ===== rtl/core/itde_pkg.sv =====
// Shared types and constants for the identifier token dedup extractor.
// No dependencies.
`timescale 1ns / 1ps
package itde_pkg;
  localparam logic [7:0] UNDERSCORE = 8'h5F;
  localparam logic [7:0] ASCII_MASK = 8'h7F;
  localparam int unsigned MIN_TOKEN_BYTES = 3;
  localparam int MAX_TOKEN_BYTES = 64;
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_content;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_bytes;
    logic [31:0] token_offset;
    logic [6:0]  token_length;
    logic        truncated;
    logic [6:0]  unique_count;
    logic        last_of_run;
  } out_item_t;

  function automatic logic is_ident(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == UNDERSCORE;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? ((b + 8'd32) & ASCII_MASK) : b;
  endfunction
endpackage

// ===== rtl/core/itde_if.sv =====
// Valid/ready channel carrying one item of type T.
// No dependencies; the payload type is set by parameter T.
`timescale 1ns / 1ps
interface itde_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/itde_word_mem.sv =====
// Token word store with registered read.
// No dependencies.
`timescale 1ns / 1ps
module itde_word_mem #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/identifier_token_dedup_extractor.sv =====
// Identifier token dedup extractor: byte in, token chunks and summaries out.
// A byte that ends no token is taken in S_IDLE. A token end adds a decision state (S_ADDR) and a
// table walk on one shared 64-bit compare over a registered read (S_ADDR, then S_CMP per entry).
// Each chunk or summary is loaded into the output register, then held until taken. One item in
// flight; input is held off until the last result is taken. End of content adds one summary.
// Reset (rst, synchronous) clears position, run, count, flag and cap; the table is read only
// below the entry count, so it needs no clearing pass.
`timescale 1ns / 1ps
module identifier_token_dedup_extractor #(
  parameter int TABLE_DEPTH = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  itde_if.sink        in_ch,
  itde_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import itde_pkg::*;
  localparam int RW = (MAX_TOKEN_BYTES + 7) / 8;
  localparam int WB = (RW > 1) ? $clog2(RW) : 1;
  localparam int EB = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CB = $clog2(TABLE_DEPTH + 1);
  localparam int LB = $clog2(MAX_TOKEN_BYTES + 2);
  localparam int AW = EB + WB;
  localparam int BB = $clog2(MAX_TOKEN_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0, S_ADDR = 3'd1, S_CMP = 3'd2,
                         S_EMIT = 3'd3, S_SUM = 3'd4;

  logic [2:0] state;
  logic [POSITION_BITS-1:0] position, run_start;
  logic in_run;
  logic [LB-1:0] run_length, tok_len;
  logic [63:0] run_buffer [RW];
  logic [6:0] tbl_len [1 << EB];
  logic [6:0] len_rd;
  logic [CB-1:0] entry_count;
  logic dropped_flag, eoc_pend;
  logic [6:0] unique_cap;
  logic [CB-1:0] ent;
  logic [WB-1:0] wrd;
  logic [WB:0] words;
  logic last_wrd;
  logic wr_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0] rd_data;
  logic [CB-1:0] eff_cap;
  out_item_t oreg;
  logic ovalid;

  assign pready = 1'b1;
  assign prdata = {25'd0, unique_cap};
  assign eff_cap = (unique_cap == 7'd0 || 32'(unique_cap) > TABLE_DEPTH) ?
                   CB'(TABLE_DEPTH) : CB'(unique_cap);
  assign words = (WB+1)'((tok_len + LB'(7)) >> 3);
  assign last_wrd = ((WB+1)'(wrd) + (WB+1)'(1)) == words;

  assign rd_addr = (state == S_CMP) ? {ent[EB-1:0], wrd + WB'(1)} : {ent[EB-1:0], wrd};
  itde_word_mem #(.DEPTH(1 << AW), .AW(AW)) u_mem (
    .clk(clk), .we(wr_we), .waddr(wr_addr), .wdata(run_buffer[wrd]),
    .raddr(rd_addr), .rdata(rd_data)
  );
  assign wr_we = (state == S_EMIT) && !ovalid;
  assign wr_addr = {entry_count[EB-1:0], wrd};

  always_ff @(posedge clk) begin
    len_rd <= tbl_len[ent[EB-1:0]];
  end

  assign in_ch.ready = (state == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.payload = oreg;

  logic [7:0] b, lc;
  logic eoc, ident, ending;
  logic [LB-1:0] len_next;
  assign b = in_ch.payload.data_byte;
  assign eoc = in_ch.payload.end_of_content;
  assign ident = is_ident(b);
  assign lc = to_lower(b);
  assign ending = in_run && (!ident || eoc);

  always_comb begin
    if (!ident) len_next = run_length;
    else if (!in_run) len_next = LB'(1);
    else if (32'(run_length) < MAX_TOKEN_BYTES) len_next = run_length + LB'(1);
    else len_next = LB'(MAX_TOKEN_BYTES + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; position <= '0; run_start <= '0; in_run <= 1'b0;
      run_length <= '0; entry_count <= '0; dropped_flag <= 1'b0;
      unique_cap <= '0; ovalid <= 1'b0; eoc_pend <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) unique_cap <= pwdata[6:0];
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            eoc_pend <= eoc;
            tok_len <= len_next;
            if (ident && !in_run) begin
              for (int i = 0; i < RW; i++) run_buffer[i] <= (i == 0) ? {56'd0, lc} : 64'd0;
              run_start <= position;
            end else if (ident && 32'(run_length) < MAX_TOKEN_BYTES) begin
              run_buffer[run_length[BB-1:3]][run_length[2:0]*8 +: 8] <= lc;
            end
            if (eoc) position <= '0;
            else position <= position + POSITION_BITS'(1);
            if (ending || (eoc && ident)) begin
              in_run <= 1'b0; run_length <= '0;
              ent <= '0; wrd <= '0; state <= S_ADDR;
            end else begin
              in_run <= in_run || ident;
              run_length <= len_next;
              if (eoc) state <= S_SUM;
            end
          end
        end
        S_ADDR: begin
          if (32'(tok_len) < MIN_TOKEN_BYTES || 32'(tok_len) > MAX_TOKEN_BYTES) begin
            state <= eoc_pend ? S_SUM : S_IDLE;
          end else if (ent >= entry_count) begin
            if (entry_count >= eff_cap) begin
              dropped_flag <= 1'b1;
              state <= eoc_pend ? S_SUM : S_IDLE;
            end else begin
              wrd <= '0; state <= S_EMIT;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (len_rd != 7'(tok_len) || rd_data != run_buffer[wrd]) begin
            wrd <= '0; ent <= ent + CB'(1); state <= S_ADDR;
          end else if (last_wrd) begin
            state <= eoc_pend ? S_SUM : S_IDLE;
          end else wrd <= wrd + WB'(1);
        end
        S_EMIT: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            oreg.result_kind <= KIND_CHUNK;
            oreg.chunk_data <= run_buffer[wrd];
            oreg.chunk_bytes <= (32'(tok_len) - 32'(wrd) * 8 > 8) ? 4'd8 :
                                4'(tok_len - LB'(wrd) * LB'(8));
            oreg.token_offset <= 32'(run_start);
            oreg.token_length <= 7'(tok_len);
            oreg.truncated <= 1'b0;
            oreg.unique_count <= '0;
            oreg.last_of_run <= last_wrd && !eoc_pend;
            if (last_wrd) begin
              tbl_len[entry_count[EB-1:0]] <= 7'(tok_len);
              entry_count <= entry_count + CB'(1);
              state <= eoc_pend ? S_SUM : S_IDLE;
            end else wrd <= wrd + WB'(1);
          end
        end
        S_SUM: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            oreg.result_kind <= KIND_SUMMARY;
            oreg.chunk_data <= '0; oreg.chunk_bytes <= '0;
            oreg.token_offset <= '0; oreg.token_length <= '0;
            oreg.truncated <= dropped_flag;
            oreg.unique_count <= 7'(entry_count);
            oreg.last_of_run <= 1'b1;
            entry_count <= '0; dropped_flag <= 1'b0; run_start <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/itde_checker.sv =====
// Port-level checks for the extractor, bound to the top level.
// Depends on itde_pkg.
`timescale 1ns / 1ps
module itde_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last,
  input logic [3:0] out_bytes,
  input logic [6:0] out_count
);
  import itde_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_SUMMARY |-> out_last) else $error("summary not last");
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_CHUNK |-> out_bytes != 4'd0 && out_bytes <= 4'd8)
    else $error("bad chunk size");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_CHUNK |-> out_count == 7'd0) else $error("count in chunk");
endmodule

bind identifier_token_dedup_extractor itde_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.payload.result_kind), .out_last(out_ch.payload.last_of_run),
  .out_bytes(out_ch.payload.chunk_bytes), .out_count(out_ch.payload.unique_count)
);
